>>> sv/assert_macros.svh
// Assertion macros shared by the RTL modules of the sample averager.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/orsa_pkg.sv
// Shared widths and register indexes for the outlier-rejecting sample averager.
// Used by orsa_div, outlier_rejecting_sample_average and the testbench; depends on nothing.
package orsa_pkg;

	// Fixed state widths.
	localparam int SUM_W      = 16;
	localparam int CNT_W      = 4;
	localparam int ATT_W      = 8;
	localparam int TOL_W      = 7;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_NEEDED_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_PCT  = 2'd2;

	// Register reset values.
	localparam logic [CNT_W-1:0] NEEDED_RESET  = 4'd5;
	localparam logic [ATT_W-1:0] ATTEMPT_RESET = 8'd25;
	localparam logic [TOL_W-1:0] TOL_RESET     = 7'd20;

	// Shared multiplier: one operand holds a sum or a sample, the other a scaled percentage
	// (at most 100 * 15), so the product needs 27 bits.
	localparam int MUL_B_W    = 11;
	localparam int MUL_P_W    = SUM_W + MUL_B_W;
	localparam int PCT_FULL   = 100;

	// Divider iteration counter.
	localparam int DIV_CNT_W  = $clog2(SUM_W);

endpackage

>>> sv/orsa_div.sv
// Iterative restoring divider: 16-bit run sum by 4-bit run count, one bit per cycle.
// Depends on orsa_pkg for the sum and count widths, and on assert_macros.svh.
module orsa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [orsa_pkg::SUM_W-1:0] dividend,
	input  logic [orsa_pkg::CNT_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [orsa_pkg::SUM_W-1:0] quotient
);
	import orsa_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	// Control: a start loads the operands, then one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		end
	end

	// An empty run averages to zero.
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;

	`include "assert_macros.svh"

	`ASSERT_NEVER(a_div_restart, start && busy_q, "divider started while busy")
	`ASSERT_ALWAYS(a_div_done_end, done_q |-> !busy_q && $past(busy_q), "done without a finished pass")
endmodule

>>> sv/outlier_rejecting_sample_average.sv
// Outlier-rejecting sample averager: top level with the sequencer and shared multiplier.
// Depends on orsa_pkg, orsa_div and assert_macros.svh.
//
// Each transferred sample is checked against the current run's mean +/- tolerance_pct
// percent by exact integer cross-multiplication on one shared multiplier, which
// runs three products in turn. A sample that produces no result passes through the
// LHS, HI, LO and CHECK states before the next input transfer. A sample that completes a
// run or uses up the attempt limit also runs the bit-serial divider and the result
// load, which waits while the output register stays full under out_stall.
// in_stall is high while a sample is in work.
// A result waits in the output register and the block takes the next sample meanwhile.
module outlier_rejecting_sample_average #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [orsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [orsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [SAMPLE_BITS-1:0]          average,
	output logic                            timed_out
);
	import orsa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LHS   = 3'd1;
	localparam logic [2:0] ST_HI    = 3'd2;
	localparam logic [2:0] ST_LO    = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       needed_q;
	logic [ATT_W-1:0]       limit_q;
	logic [TOL_W-1:0]       tol_q;
	logic [SUM_W-1:0]       run_sum_q;
	logic [CNT_W-1:0]       run_count_q;
	logic [ATT_W-1:0]       attempts_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic [MUL_P_W-1:0]     lhs_q;
	logic                   hi_fail_q;
	logic                   tmo_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] average_q;
	logic                   timed_out_q;

	logic [SUM_W-1:0]       mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [MUL_P_W-1:0]     mul_p;
	logic                   in_xfer;
	logic                   out_free;
	logic                   outlier;
	logic [SUM_W:0]         sum_next;
	logic                   done_run;
	logic                   done_tmo;
	logic                   div_start;
	logic                   div_busy;
	logic                   div_done;
	logic [SUM_W-1:0]       div_quo;

	assign in_stall  = state_q != ST_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Shared multiplier operands: x * 100n, then S * (100 + tol), then S * (100 - tol).
	always_comb begin
		mul_a = run_sum_q;
		mul_b = '0;
		case (state_q)
			ST_LHS: begin
				mul_a = SUM_W'(x_q);
				mul_b = MUL_B_W'(run_count_q) * MUL_B_W'(PCT_FULL);
			end
			ST_HI: begin
				mul_b = MUL_B_W'(PCT_FULL) + MUL_B_W'(tol_q);
			end
			ST_LO: begin
				mul_b = (tol_q >= TOL_W'(PCT_FULL)) ? '0
					: MUL_B_W'(PCT_FULL) - MUL_B_W'(tol_q);
			end
			default: begin
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// The lower bound is zero for a tolerance of 100 or more, so nothing is too low then.
	assign outlier  = (run_count_q != '0) && (hi_fail_q || (lhs_q < mul_p));
	assign sum_next = {1'b0, run_sum_q} + (SUM_W + 1)'(x_q);

	// A complete run wins over a timeout on the same sample.
	assign done_run  = run_count_q >= needed_q;
	assign done_tmo  = !done_run && (attempts_q >= limit_q);
	assign div_start = (state_q == ST_CHECK) && (done_run || done_tmo);

	orsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (run_sum_q),
		.divisor  (run_count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Config registers; the user writes only while the block is idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= NEEDED_RESET;
			limit_q  <= ATTEMPT_RESET;
			tol_q    <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEEDED_SAMPLES: needed_q <= cfg_data[CNT_W-1:0];
				CFG_ATTEMPT_LIMIT:  limit_q  <= cfg_data[ATT_W-1:0];
				CFG_TOLERANCE_PCT:  tol_q    <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_sum_q   <= '0;
			run_count_q <= '0;
			attempts_q  <= '0;
			tmo_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						attempts_q <= attempts_q + 1'b1;
						state_q    <= ST_LHS;
					end
				end
				ST_LHS: begin
					state_q <= ST_HI;
				end
				ST_HI: begin
					state_q <= ST_LO;
				end
				ST_LO: begin
					if (outlier) begin
						run_sum_q   <= SUM_W'(x_q);
						run_count_q <= CNT_W'(1);
					end else begin
						run_sum_q   <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
						run_count_q <= run_count_q + 1'b1;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (div_start) begin
						tmo_q       <= done_tmo;
						run_sum_q   <= '0;
						run_count_q <= '0;
						attempts_q  <= '0;
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample and product registers of the outlier test.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= sample;
		end
		if (state_q == ST_LHS) begin
			lhs_q <= mul_p;
		end
		if (state_q == ST_HI) begin
			hi_fail_q <= lhs_q > mul_p;
		end
	end

	// Output register; a result loads once the previous one has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			average_q   <= SAMPLE_BITS'(div_quo);
			timed_out_q <= tmo_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign timed_out = timed_out_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_count_le_attempts, ATT_W'(run_count_q) <= attempts_q, "run longer than attempts used")
	`ASSERT_ALWAYS(a_div_done_state, div_done |-> state_q == ST_DIV, "divider finished outside the divide state")
	`ASSERT_ALWAYS(a_div_idle_at_start, div_start |-> !div_busy, "divider started while busy")
	`ASSERT_ALWAYS(a_state_cleared, (state_q == ST_DIV) |-> (run_count_q == '0 && attempts_q == '0), "state not cleared after a result")
endmodule

>>> sim/tb_outlier_rejecting_sample_average.sv
// Self-checking testbench for outlier_rejecting_sample_average: a queue-fed driver,
// a checking monitor and a predictor of the run, outlier and timeout rules.
// Depends on orsa_pkg and the RTL of the sample averager.
module tb_outlier_rejecting_sample_average;
	timeunit 1ns;
	timeprecision 1ps;

	import orsa_pkg::*;

	localparam int SAMPLE_BITS   = 12;
	localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 1500;

	// Index past the end of the register list; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] average;
		logic                   timed_out;
	} mean_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = '0;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] sample     = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [SAMPLE_BITS-1:0] average;
	logic                   timed_out;

	// Predictor copy of the registers and the measurement state.
	logic [CNT_W-1:0]       need_cfg   = NEEDED_RESET;
	logic [ATT_W-1:0]       limit_cfg  = ATTEMPT_RESET;
	logic [TOL_W-1:0]       tol_cfg    = TOL_RESET;
	logic [SUM_W-1:0]       acc_sum    = '0;
	logic [CNT_W-1:0]       acc_count  = '0;
	logic [ATT_W-1:0]       tries      = '0;

	logic [SAMPLE_BITS-1:0] pending_samples[$];
	mean_t                  expected_means[$];
	mean_t                  fresh_mean;
	mean_t                  want;
	int                     in_gap_max    = 3;
	int                     out_stall_max = 3;
	int                     in_wait       = 0;
	int                     hold_left     = 0;
	int                     mismatches    = 0;
	int unsigned            cycle_count   = 0;

	outlier_rejecting_sample_average #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.average   (average),
		.timed_out (timed_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Folds one sample into the run and returns 1 when it ends the measurement.
	// The outlier test compares x*100*n against the sum scaled by 100 +/- tolerance.
	function automatic bit fold_in_sample(input logic [SAMPLE_BITS-1:0] x,
			output mean_t res);
		longint unsigned scaled;
		longint unsigned upper;
		longint unsigned lower;
		int unsigned     grown;
		bit              off_band;
		bit              complete;
		bit              expired;
		tries = tries + 1'b1;
		off_band = 1'b0;
		if (acc_count != 0) begin
			scaled = 64'(x) * PCT_FULL * acc_count;
			upper = 64'(acc_sum) * (PCT_FULL + tol_cfg);
			lower = (tol_cfg >= PCT_FULL) ? 64'd0 : 64'(acc_sum) * (PCT_FULL - tol_cfg);
			off_band = (scaled > upper) || (scaled < lower);
		end
		if (off_band) begin
			acc_sum = SUM_W'(x);
			acc_count = 1;
		end else begin
			grown = acc_sum + x;
			acc_sum = (grown > 32'hFFFF) ? 16'hFFFF : grown[SUM_W-1:0];
			acc_count = acc_count + 1'b1;
		end
		complete = acc_count >= need_cfg;
		expired = !complete && tries >= limit_cfg;
		res = '0;
		if (!complete && !expired)
			return 1'b0;
		res.average = SAMPLE_BITS'(acc_sum / acc_count);
		res.timed_out = expired;
		acc_sum = '0;
		acc_count = '0;
		tries = '0;
		return 1'b1;
	endfunction

	// Input driver: one sample per transfer, with a random gap drawn per item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			in_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (fold_in_sample(sample, fresh_mean))
					expected_means.push_back(fresh_mean);
			end
			if (!in_valid || !in_stall) begin
				if (in_wait != 0) begin
					in_valid <= 1'b0;
					in_wait <= in_wait - 1;
				end else if (pending_samples.size() != 0) begin
					in_valid <= 1'b1;
					sample <= pending_samples.pop_front();
					in_wait <= $urandom_range(0, in_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer against the oldest expected mean, then
	// stalls for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected result average %0d timed_out %0b",
						$realtime, average, timed_out);
					mismatches++;
				end else begin
					want = expected_means.pop_front();
					if (average !== want.average) begin
						$display("%0t: average expected %0d actual %0d",
							$realtime, want.average, average);
						mismatches++;
					end
					if (timed_out !== want.timed_out) begin
						$display("%0t: timed_out expected %0b actual %0b",
							$realtime, want.timed_out, timed_out);
						mismatches++;
					end
				end
				hold_left = $urandom_range(0, out_stall_max);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	// Writes one register and mirrors the write into the predictor.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NEEDED_SAMPLES: need_cfg = data[CNT_W-1:0];
			CFG_ATTEMPT_LIMIT:  limit_cfg = data[ATT_W-1:0];
			CFG_TOLERANCE_PCT:  tol_cfg = data[TOL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits until every sample is taken and every result is back, then lets a
	// sample that ends without a result finish its work.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_means.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int  queued;
		int  phase_end;
		int  kind;
		int  base;
		int  spread;
		int  run_n;
		int  val;
		int  need;
		int  lim;
		int  tol;
		bit  extreme;

		queued = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: all-zero and all-ones runs.
		repeat (5) pending_samples.push_back('0);
		repeat (5) pending_samples.push_back(SAMPLE_BITS'(SAMPLE_TOP));
		settle();

		// Zero run length and zero attempt limit: every sample completes a run.
		write_reg(CFG_NEEDED_SAMPLES, 8'hF0);
		write_reg(CFG_ATTEMPT_LIMIT, 8'h00);
		write_reg(CFG_TOLERANCE_PCT, 8'hFF);
		pending_samples.push_back(12'h5A5);
		pending_samples.push_back(12'hA5A);
		settle();

		// Longest run with zero attempt limit: every sample times out.
		write_reg(CFG_NEEDED_SAMPLES, 8'h0F);
		pending_samples.push_back(12'h001);
		pending_samples.push_back(12'hFFE);
		settle();

		// Write past the register list, then tolerance above 100: no lower bound.
		write_reg(CFG_SPARE, 8'hFF);
		write_reg(CFG_NEEDED_SAMPLES, 8'h02);
		write_reg(CFG_ATTEMPT_LIMIT, 8'hFF);
		pending_samples.push_back(12'd1000);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'd10);
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd4095);
		settle();

		// Run completes on the same sample that reaches the limit: not a timeout.
		write_reg(CFG_NEEDED_SAMPLES, 8'h03);
		write_reg(CFG_ATTEMPT_LIMIT, 8'h03);
		write_reg(CFG_TOLERANCE_PCT, 8'h80);
		repeat (3) pending_samples.push_back(12'd100);
		settle();

		// Every sample restarts the run, so the limit ends the measurement.
		write_reg(CFG_NEEDED_SAMPLES, 8'h04);
		pending_samples.push_back(12'd100);
		pending_samples.push_back(12'd200);
		pending_samples.push_back(12'd300);
		settle();

		// Random phases: new settings each phase, mostly agreeing runs around a
		// base value with stray outliers, some pure noise.
		while (queued < RANDOM_ITEMS) begin
			extreme = ($urandom_range(0, 3) == 0);
			if (extreme) begin
				need = $urandom_range(0, 1) ? 15 : 1;
				lim = $urandom_range(0, 1) ? 255 : 1;
				case ($urandom_range(0, 2))
					0: tol = 0;
					1: tol = 99;
					default: tol = 127;
				endcase
			end else begin
				need = $urandom_range(1, 15);
				lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
					: $urandom_range(need, 4 * need);
				tol = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 127)
					: $urandom_range(0, 99);
			end
			write_reg(CFG_NEEDED_SAMPLES, {4'($urandom), 4'(need)});
			write_reg(CFG_ATTEMPT_LIMIT, 8'(lim));
			write_reg(CFG_TOLERANCE_PCT, {1'($urandom), 7'(tol)});
			in_gap_max = $urandom_range(0, 1) ? 8 : 0;
			out_stall_max = $urandom_range(0, 1) ? 8 : 0;

			phase_end = queued + $urandom_range(30, 120);
			while (queued < phase_end) begin
				kind = $urandom_range(0, 9);
				if (kind < 2) begin
					pending_samples.push_back(SAMPLE_BITS'($urandom));
					queued++;
				end else begin
					case (kind)
						2: base = $urandom_range(0, 15);
						3: base = $urandom_range(SAMPLE_TOP - 15, SAMPLE_TOP);
						default: base = $urandom_range(0, SAMPLE_TOP);
					endcase
					spread = base * tol / 300;
					run_n = need + $urandom_range(0, 2);
					for (int i = 0; i < run_n; i++) begin
						if ($urandom_range(0, 11) == 0)
							val = $urandom_range(0, SAMPLE_TOP);
						else
							val = base - spread + int'($urandom_range(0, 2 * spread));
						if (val > SAMPLE_TOP)
							val = SAMPLE_TOP;
						pending_samples.push_back(SAMPLE_BITS'(val));
						queued++;
					end
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
